// ===== rtl/core/vin_pkg.sv =====
`default_nettype none

package vin_pkg;

    // sample and result geometry
    localparam int SAMPLE_WIDTH = 16;
    localparam int MAG_W        = SAMPLE_WIDTH;
    localparam int SQ_W         = 2 * SAMPLE_WIDTH;
    localparam int ROOT_STEPS   = SAMPLE_WIDTH;
    localparam int STEP_CNT_W   = $clog2(ROOT_STEPS);
    localparam int IN_DATA_W    = 2 * SAMPLE_WIDTH;

    // controller states
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_ROOT,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic sqrt_load;
        logic sqrt_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_in_pipe;
        logic last_at_tail;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/vin_ctrl.sv =====
`default_nettype none

module vin_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vin_pkg::t_dp_status i_status,
    output vin_pkg::t_dp_cmd         o_cmd,
    output logic                     o_in_ready
);
    import vin_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [STEP_CNT_W-1:0] r_step_cnt;
    logic [STEP_CNT_W-1:0] n_step_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_ACCUM;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_in_ready = !i_status.last_in_pipe;
                if (i_status.last_at_tail) begin
                    o_cmd.sqrt_load = 1'b1;
                    n_step_cnt      = '0;
                    n_state         = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step_cnt      = r_step_cnt + 1'b1;
                if (r_step_cnt == STEP_CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/vin_datapath.sv =====
`default_nettype none

module vin_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic                                i_cfg_wr_data,
    input  wire logic                                i_in_accept,
    input  wire logic signed [vin_pkg::MAG_W-1:0]    i_real_part,
    input  wire logic signed [vin_pkg::MAG_W-1:0]    i_imag_part,
    input  wire logic                                i_last,
    input  wire logic                                i_out_ready,
    input  wire vin_pkg::t_dp_cmd                    i_cmd,
    output vin_pkg::t_dp_status                      o_status,
    output logic                                     o_out_valid,
    output logic [vin_pkg::SAMPLE_WIDTH-1:0]         o_norm
);
    import vin_pkg::*;

    localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (SQ_W - 2);

    logic                     r_complex_mode;
    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic [MAG_W-1:0]         r_s1_mag_re;
    logic [MAG_W-1:0]         r_s1_mag_im;
    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic [SQ_W-1:0]          r_s2_sq_re;
    logic [SQ_W-1:0]          r_s2_sq_im;
    logic [SQ_W-1:0]          r_run_max;
    logic [SQ_W-1:0]          r_rem;
    logic [SQ_W-1:0]          r_res;
    logic [SQ_W-1:0]          r_bit;
    logic [SAMPLE_WIDTH-1:0]  r_out_data;
    logic                     r_out_valid;

    logic [MAG_W-1:0]         w_mag_re;
    logic [MAG_W-1:0]         w_mag_im;
    logic [SQ_W-1:0]          w_sq_re;
    logic [SQ_W-1:0]          w_sq_im;
    logic [SQ_W-1:0]          w_sum;
    logic [SQ_W-1:0]          w_new_max;
    logic [SQ_W-1:0]          w_trial;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complex_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_complex_mode <= i_cfg_wr_data;
        end
    end

    // absolute values, imaginary part dropped in real mode
    assign w_mag_re = i_real_part[MAG_W-1] ? MAG_W'(~i_real_part + 1'b1) : MAG_W'(i_real_part);
    assign w_mag_im = !r_complex_mode ? '0 :
                      i_imag_part[MAG_W-1] ? MAG_W'(~i_imag_part + 1'b1) : MAG_W'(i_imag_part);

    // stage 1: magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_in_accept;
        end
        if (i_in_accept) begin
            r_s1_last   <= i_last;
            r_s1_mag_re <= w_mag_re;
            r_s1_mag_im <= w_mag_im;
        end
    end

    // stage 2: squares
    assign w_sq_re = SQ_W'(r_s1_mag_re) * SQ_W'(r_s1_mag_re);
    assign w_sq_im = SQ_W'(r_s1_mag_im) * SQ_W'(r_s1_mag_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_s2_last  <= r_s1_last;
            r_s2_sq_re <= w_sq_re;
            r_s2_sq_im <= w_sq_im;
        end
    end

    // running maximum, cleared once the vector end is folded in
    assign w_sum     = r_s2_sq_re + r_s2_sq_im;
    assign w_new_max = (w_sum > r_run_max) ? w_sum : r_run_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= '0;
        end else if (r_s2_valid) begin
            r_run_max <= r_s2_last ? '0 : w_new_max;
        end
    end

    // floor square root, one result bit per step
    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_rem <= w_new_max;
            r_res <= '0;
            r_bit <= BIT_INIT;
        end else if (i_cmd.sqrt_step) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res[SAMPLE_WIDTH-1:0];
        end
    end

    // status back to the controller
    assign o_status.last_in_pipe = (r_s1_valid && r_s1_last) || (r_s2_valid && r_s2_last);
    assign o_status.last_at_tail = r_s2_valid && r_s2_last;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_norm      = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/vector_infinity_norm.sv =====
// throughput: one sample per cycle inside a vector; the 16-step restoring square root
// holds off input after each vector end
// a finished norm waits in the output register while the next vector streams in
// reset: synchronous, active low; clears the running maximum, valids and state,
// and sets complex_mode to 1
`default_nettype none

module vector_infinity_norm (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic                               i_cfg_wr_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [vin_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // real_part, imag_part
    input  wire logic                               s_axis_tlast,  // last
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [vin_pkg::SAMPLE_WIDTH-1:0]        m_axis_tdata   // norm
);
    import vin_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_accept;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    // sequencer
    vin_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    // accumulation, square root and output register
    vin_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_accept   (w_in_accept),
        .i_real_part   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_imag_part   (s_axis_tdata[IN_DATA_W-1:SAMPLE_WIDTH]),
        .i_last        (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (m_axis_tvalid),
        .o_norm        (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // no second sample enters right behind a vector end
    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after a vector end");

    // a root start blocks input and begins the root steps
    a_hold_during_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sqrt_load |=> (!s_axis_tready && w_cmd.sqrt_step))
        else $error("root start did not block input");

    // a loaded norm is presented next cycle
    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("norm loaded but not valid");

    // a pending norm is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_cmd.out_load)
        else $error("pending norm overwritten");
`endif

endmodule

`default_nettype wire
